>>> hw/rtl/jbhe_pkg.sv
package jbhe_pkg;

    localparam int BLOCK_COEFFS = 64;
    localparam logic [5:0] LAST_POS = 6'(BLOCK_COEFFS - 1);

    typedef struct packed {
        logic               command;
        logic signed [11:0] coefficient;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_t;

    localparam logic CMD_COEFF = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] SYM_ZRL = 8'hF0;
    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_D9 = 8'hD9;
    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [15:0] PAD_CODE = 16'h007F;
    localparam logic [4:0]  PAD_LEN  = 5'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_ZRL, ST_SYM, ST_VAL, ST_UPD, ST_TAIL,
        ST_PAD, ST_CLR, ST_MFF, ST_MD9, ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        LD_ZRL, LD_SYM_DC, LD_SYM_AC, LD_VAL, LD_EOB, LD_PAD
    } load_sel_t;

    typedef struct packed {
        logic      latch;
        logic      load;
        load_sel_t load_sel;
        logic      emit_lit;
        logic      lit_d9;
        logic      clear_acc;
        logic      upd;
        logic      adv;
        logic      zrl_dec;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic can_emit;
        logic flush;
        logic is_dc;
        logic coef_zero;
        logic run_gt15;
        logic need_eob;
    } stat_t;

    // code table entry: length in [20:16], right aligned code in [15:0]
    typedef logic [255:0][20:0] rom_t;
    typedef logic [0:15][7:0]   counts_t;
    typedef logic [0:161][7:0]  syms_t;

    localparam counts_t DC_COUNTS = {8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                     8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam counts_t AC_COUNTS = {8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                     8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
    localparam syms_t DC_SYMS = {8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
                                 8'd8, 8'd9, 8'd10, 8'd11, {150{8'd0}}};
    localparam syms_t AC_SYMS = {
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
        8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
        8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
        8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
        8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
        8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
        8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
        8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
        8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

    // canonical code assignment, evaluated at elaboration only
    function automatic rom_t build_rom(counts_t counts, syms_t syms, int nsyms);
        rom_t rom;
        int   c;
        int   k;
        rom = '0;
        c = 0;
        k = 0;
        for (int l = 0; l < 16; l++)
        begin
            for (int j = 0; j < 256; j++)
            begin
                if (j < int'(counts[l]) && k < nsyms)
                begin
                    rom[syms[k]] = {5'(l + 1), 16'(c)};
                    c = c + 1;
                    k = k + 1;
                end
            end
            c = c * 2;
        end
        return rom;
    endfunction

    localparam rom_t DC_ROM = build_rom(DC_COUNTS, DC_SYMS, 12);
    localparam rom_t AC_ROM = build_rom(AC_COUNTS, AC_SYMS, 162);

endpackage

>>> hw/rtl/jbhe_ctrl.sv
module jbhe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  jbhe_pkg::stat_t stat,
    output jbhe_pkg::cmd_t  cmd
);

    jbhe_pkg::state_t state_reg;
    jbhe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jbhe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load_sel = jbhe_pkg::LD_VAL;
        in_ready     = 1'b0;
        case (state_reg)
            jbhe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = jbhe_pkg::ST_EVAL;
                end
            end
            jbhe_pkg::ST_EVAL:
            begin
                if (stat.flush)
                    state_next = jbhe_pkg::ST_PAD;
                else if (stat.is_dc)
                    state_next = jbhe_pkg::ST_SYM;
                else if (stat.coef_zero)
                    state_next = jbhe_pkg::ST_UPD;
                else
                    state_next = jbhe_pkg::ST_ZRL;
            end
            jbhe_pkg::ST_ZRL:
            begin
                if (!stat.run_gt15)
                    state_next = jbhe_pkg::ST_SYM;
                else if (!stat.busy)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = jbhe_pkg::LD_ZRL;
                    cmd.zrl_dec  = 1'b1;
                end
            end
            jbhe_pkg::ST_SYM:
            begin
                if (!stat.busy)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = stat.is_dc ? jbhe_pkg::LD_SYM_DC : jbhe_pkg::LD_SYM_AC;
                    state_next   = jbhe_pkg::ST_VAL;
                end
            end
            jbhe_pkg::ST_VAL:
            begin
                if (!stat.busy)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = jbhe_pkg::LD_VAL;
                    state_next   = jbhe_pkg::ST_UPD;
                end
            end
            jbhe_pkg::ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = jbhe_pkg::ST_TAIL;
            end
            jbhe_pkg::ST_TAIL:
            begin
                if (!stat.need_eob)
                begin
                    cmd.adv    = 1'b1;
                    state_next = jbhe_pkg::ST_FIN;
                end
                else if (!stat.busy)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = jbhe_pkg::LD_EOB;
                    cmd.adv      = 1'b1;
                    state_next   = jbhe_pkg::ST_FIN;
                end
            end
            jbhe_pkg::ST_PAD:
            begin
                if (!stat.busy)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = jbhe_pkg::LD_PAD;
                    state_next   = jbhe_pkg::ST_CLR;
                end
            end
            jbhe_pkg::ST_CLR:
            begin
                if (!stat.busy)
                begin
                    cmd.clear_acc = 1'b1;
                    state_next    = jbhe_pkg::ST_MFF;
                end
            end
            jbhe_pkg::ST_MFF:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_lit = 1'b1;
                    state_next   = jbhe_pkg::ST_MD9;
                end
            end
            jbhe_pkg::ST_MD9:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_lit = 1'b1;
                    cmd.lit_d9   = 1'b1;
                    state_next   = jbhe_pkg::ST_FIN;
                end
            end
            jbhe_pkg::ST_FIN:
            begin
                if (!stat.busy && stat.can_emit)
                begin
                    cmd.finish = 1'b1;
                    state_next = jbhe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jbhe_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !stat.busy)
        else $error("bit load while drain active");
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.emit_lit))
        else $error("load and literal in one cycle");

endmodule

>>> hw/rtl/jbhe_dp.sv
module jbhe_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  jbhe_pkg::in_t   in_data,
    input  jbhe_pkg::cmd_t  cmd,
    output jbhe_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_ready,
    output jbhe_pkg::out_t  out_data
);

    logic               flush_reg;
    logic signed [11:0] coef_reg;
    logic signed [11:0] prev_dc_reg;
    logic [5:0]         run_reg;
    logic [5:0]         scan_reg;
    logic [22:0]        acc_reg;
    logic [4:0]         cnt_reg;
    logic               stuff_reg;
    logic [7:0]         hold_reg;
    logic               hold_v_reg;
    logic               out_v_reg;
    jbhe_pkg::out_t     out_reg;

    logic               is_dc;
    logic signed [12:0] diff;
    logic signed [11:0] dsat;
    logic signed [11:0] asat;
    logic signed [11:0] val;
    logic [10:0]        mag;
    logic [3:0]         nsz;
    logic [11:0]        vbits;
    logic [7:0]         sym;
    logic [20:0]        entry;
    logic [15:0]        code;
    logic [4:0]         len;
    logic [22:0]        mask;
    logic               drain_busy;
    logic               out_free;
    logic               can_emit;
    logic               emit;
    logic [7:0]         emit_byte;
    logic [7:0]         drain_byte;

    assign is_dc = (scan_reg == 6'd0);
    assign diff  = 13'(coef_reg) - 13'(prev_dc_reg);

    always_comb
    begin
        if (diff > 13'sd2047)
            dsat = 12'sd2047;
        else if (diff < -13'sd2047)
            dsat = -12'sd2047;
        else
            dsat = 12'(diff);
        if (coef_reg > 12'sd1023)
            asat = 12'sd1023;
        else if (coef_reg < -12'sd1023)
            asat = -12'sd1023;
        else
            asat = coef_reg;
        val   = is_dc ? dsat : asat;
        mag   = val[11] ? 11'(-val) : 11'(val);
        vbits = val[11] ? 12'(val - 12'sd1) : 12'(val);
        nsz   = 4'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (mag[i])
                nsz = 4'(i + 1);
        end
    end

    always_comb
    begin
        sym = jbhe_pkg::SYM_EOB;
        case (cmd.load_sel)
            jbhe_pkg::LD_ZRL:    sym = jbhe_pkg::SYM_ZRL;
            jbhe_pkg::LD_SYM_AC: sym = {run_reg[3:0], nsz};
            jbhe_pkg::LD_SYM_DC: sym = {4'd0, nsz};
            default:             sym = jbhe_pkg::SYM_EOB;
        endcase
        entry = (cmd.load_sel == jbhe_pkg::LD_SYM_DC) ? jbhe_pkg::DC_ROM[sym]
                                                     : jbhe_pkg::AC_ROM[sym];
        case (cmd.load_sel)
            jbhe_pkg::LD_VAL:
            begin
                code = {4'd0, vbits};
                len  = {1'b0, nsz};
            end
            jbhe_pkg::LD_PAD:
            begin
                code = jbhe_pkg::PAD_CODE;
                len  = jbhe_pkg::PAD_LEN;
            end
            default:
            begin
                code = entry[15:0];
                len  = entry[20:16];
            end
        endcase
        mask = (23'd1 << len) - 23'd1;
    end

    assign drain_busy = stuff_reg || (cnt_reg >= 5'd8);
    assign drain_byte = 8'(acc_reg >> (cnt_reg - 5'd8));
    assign out_free   = !out_v_reg || out_ready;
    assign can_emit   = !hold_v_reg || out_free;
    assign emit       = can_emit && (drain_busy || cmd.emit_lit);

    always_comb
    begin
        if (cmd.emit_lit)
            emit_byte = cmd.lit_d9 ? jbhe_pkg::BYTE_D9 : jbhe_pkg::BYTE_FF;
        else if (stuff_reg)
            emit_byte = jbhe_pkg::BYTE_00;
        else
            emit_byte = drain_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg   <= 1'b0;
            coef_reg    <= '0;
            prev_dc_reg <= '0;
            run_reg     <= '0;
            scan_reg    <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            stuff_reg   <= 1'b0;
            hold_reg    <= '0;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                flush_reg <= (in_data.command == jbhe_pkg::CMD_FLUSH);
                coef_reg  <= in_data.coefficient;
            end
            if (cmd.zrl_dec)
                run_reg <= run_reg - 6'd16;
            if (cmd.upd)
            begin
                if (is_dc)
                begin
                    prev_dc_reg <= coef_reg;
                    run_reg     <= '0;
                end
                else if (coef_reg == 12'sd0)
                    run_reg <= run_reg + 6'd1;
                else
                    run_reg <= '0;
            end
            if (cmd.adv)
            begin
                if (scan_reg == jbhe_pkg::LAST_POS)
                begin
                    scan_reg <= '0;
                    run_reg  <= '0;
                end
                else
                    scan_reg <= scan_reg + 6'd1;
            end

            // bit buffer: load a code, clear it, or drain one byte
            if (cmd.load)
            begin
                acc_reg <= (acc_reg << len) | ({7'd0, code} & mask);
                cnt_reg <= cnt_reg + len;
            end
            else if (cmd.clear_acc)
            begin
                cnt_reg   <= '0;
                stuff_reg <= 1'b0;
            end
            else if (emit && !cmd.emit_lit)
            begin
                if (stuff_reg)
                    stuff_reg <= 1'b0;
                else
                begin
                    cnt_reg   <= cnt_reg - 5'd8;
                    stuff_reg <= (drain_byte == jbhe_pkg::BYTE_FF);
                end
            end

            // hold back one byte so the last one of an item can be marked
            if (emit)
            begin
                hold_reg   <= emit_byte;
                hold_v_reg <= 1'b1;
                if (hold_v_reg)
                    out_reg <= '{out_byte: hold_reg, last_byte: 1'b0};
            end
            else if (cmd.finish && hold_v_reg)
            begin
                out_reg    <= '{out_byte: hold_reg, last_byte: 1'b1};
                hold_v_reg <= 1'b0;
            end

            if ((emit || cmd.finish) && hold_v_reg)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    assign stat.busy      = drain_busy;
    assign stat.can_emit  = can_emit;
    assign stat.flush     = flush_reg;
    assign stat.is_dc     = is_dc;
    assign stat.coef_zero = (coef_reg == 12'sd0);
    assign stat.run_gt15  = (run_reg > 6'd15);
    assign stat.need_eob  = (scan_reg == jbhe_pkg::LAST_POS) && (run_reg != 6'd0);
    assign out_valid      = out_v_reg;
    assign out_data       = out_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'd23)
        else $error("bit count overflow");
    a_stuff_ff: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_reg |-> (hold_v_reg && hold_reg == jbhe_pkg::BYTE_FF))
        else $error("stuffing pending without FF held");
    a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.adv && scan_reg == jbhe_pkg::LAST_POS) |=> (scan_reg == 6'd0 && run_reg == 6'd0))
        else $error("block end did not wrap");

endmodule

>>> hw/rtl/jpeg_baseline_huffman_encoder.sv
// Baseline JPEG entropy coder with the standard luminance tables. Feed quantized
// coefficients in zigzag order, DC first of every 64; command 1 flushes the bit
// buffer with one-padding and appends FF D9. Output words are stream bytes with
// 0x00 stuffed after every FF data byte; last_byte marks the final byte an input
// caused. One item is handled at a time, and the rate for a coded coefficient is
// bounded by the single byte-wide output port that drains the bit buffer. The
// output register lets the next item enter while a byte still waits to be
// taken.
module jpeg_baseline_huffman_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  jbhe_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output jbhe_pkg::out_t out_data
);

    jbhe_pkg::cmd_t  cmd;
    jbhe_pkg::stat_t stat;

    jbhe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jbhe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
